[design/tcpsq_pkg.sv]
package tcpsq_pkg;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned SVC_W   = 16;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned ENTRY_W = ID_W + SVC_W;

  typedef enum logic [1:0] {
    OP_ADD_NORMAL   = 2'd0,
    OP_ADD_PRIORITY = 2'd1,
    OP_TICK         = 2'd2,
    OP_REMOVE       = 2'd3
  } op_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    op_t              op;
    logic             is_add;
    logic             is_prio;
    logic [ID_W-1:0]  order_id;
    logic [SVC_W-1:0] service_time;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               busy_res;
    logic               done_res;
    logic [ID_W-1:0]    removed_id;
    logic               removed_priority;
    logic [TOTAL_W-1:0] normal_wait;
    logic [TOTAL_W-1:0] priority_wait;
    logic [TOTAL_W-1:0] current_time;
  } res_t;

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [SVC_W-1:0] b);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, a} + (TOTAL_W+1)'(b);
    return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
  endfunction

endpackage

[design/tcpsq_front.sv]
module tcpsq_front
  import tcpsq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [1:0]       req_type,
  input  logic [ID_W-1:0]  order_id,
  input  logic [SVC_W-1:0] service_time,
  output logic             full,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  logic             cmd_pop
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       incoming;
  logic       do_push;
  logic       do_pop;

  // decode the request once so the back end also gets add and priority flags beside the op
  always_comb begin
    incoming.op           = op_t'(req_type);
    incoming.is_add       = (incoming.op == OP_ADD_NORMAL) || (incoming.op == OP_ADD_PRIORITY);
    incoming.is_prio      = (incoming.op == OP_ADD_PRIORITY);
    incoming.order_id     = order_id;
    incoming.service_time = service_time;
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

[design/tcpsq_res_fifo.sv]
module tcpsq_res_fifo
  import tcpsq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  res_t wr_data,
  output logic res_full,
  output logic empty,
  output res_t rd_data,
  input  logic pop
);

  res_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign rd_data  = slots[rd_ptr];
  assign do_push  = wr_en && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

[design/tcpsq_back.sv]
module tcpsq_back
  import tcpsq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_valid,
  output res_t res
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  logic [ENTRY_W-1:0] mem_n [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] mem_p [QUEUE_DEPTH];

  logic [ENTRY_W-1:0] n_head, n_after, p_head, p_after;
  cmd_t               cur;

  logic [PTR_W-1:0]   n_rd, n_wr, p_rd, p_wr;
  logic [CNT_W-1:0]   n_cnt, p_cnt;
  logic [SVC_W-1:0]   n_left, p_left;
  logic [TOTAL_W-1:0] n_wait, p_wait, tick;

  logic [PTR_W-1:0]   n_rd_next, n_wr_next, p_rd_next, p_wr_next;
  logic [CNT_W-1:0]   n_cnt_next, p_cnt_next;
  logic [SVC_W-1:0]   n_left_next, p_left_next;
  logic [TOTAL_W-1:0] n_wait_next, p_wait_next, tick_next;
  logic               wr_n, wr_p;
  logic [ENTRY_W-1:0] wr_entry;
  logic [PTR_W-1:0]   n_rd_inc, p_rd_inc;
  logic               take;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  assign n_rd_inc = ptr_inc(n_rd);
  assign p_rd_inc = ptr_inc(p_rd);
  assign take     = (state == S_IDLE) && cmd_valid && !res_full;
  assign cmd_pop  = take;
  assign wr_entry = {cur.service_time, cur.order_id};

  // head and the entry behind it are read on the take cycle, used on the next
  always_ff @(posedge clk) begin
    if (wr_n) begin
      mem_n[n_wr] <= wr_entry;
    end
    if (take) begin
      n_head  <= mem_n[n_rd];
      n_after <= mem_n[n_rd_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_p) begin
      mem_p[p_wr] <= wr_entry;
    end
    if (take) begin
      p_head  <= mem_p[p_rd];
      p_after <= mem_p[p_rd_inc];
    end
  end

  always_comb begin
    n_rd_next   = n_rd;
    n_wr_next   = n_wr;
    p_rd_next   = p_rd;
    p_wr_next   = p_wr;
    n_cnt_next  = n_cnt;
    p_cnt_next  = p_cnt;
    n_left_next = n_left;
    p_left_next = p_left;
    n_wait_next = n_wait;
    p_wait_next = p_wait;
    tick_next   = tick;
    wr_n        = 1'b0;
    wr_p        = 1'b0;
    res         = '0;

    if (state == S_EXEC) begin
      unique case (cur.op)
        OP_ADD_NORMAL, OP_ADD_PRIORITY: begin
          if (cur.is_prio) begin
            if (p_cnt == FULL_CNT) begin
              res.status = STATUS_FULL;
            end else begin
              wr_p        = 1'b1;
              p_wr_next   = ptr_inc(p_wr);
              p_cnt_next  = p_cnt + CNT_W'(1);
              if (p_cnt == '0) begin
                p_left_next = cur.service_time;
              end
              n_wait_next = sat_add(n_wait, cur.service_time);
              p_wait_next = sat_add(p_wait, cur.service_time);
            end
          end else begin
            if (n_cnt == FULL_CNT) begin
              res.status = STATUS_FULL;
            end else begin
              wr_n        = 1'b1;
              n_wr_next   = ptr_inc(n_wr);
              n_cnt_next  = n_cnt + CNT_W'(1);
              if (n_cnt == '0) begin
                n_left_next = cur.service_time;
              end
              n_wait_next = sat_add(n_wait, cur.service_time);
            end
          end
        end
        OP_TICK: begin
          tick_next = tick + TOTAL_W'(1);
          priority if (p_cnt != '0) begin
            res.busy_res = 1'b1;
            res.done_res = (p_left <= SVC_W'(1));
            if (p_left != '0) begin
              p_left_next = p_left - SVC_W'(1);
            end
          end else if (n_cnt != '0) begin
            res.busy_res = 1'b1;
            res.done_res = (n_left <= SVC_W'(1));
            if (n_left != '0) begin
              n_left_next = n_left - SVC_W'(1);
            end
          end
        end
        OP_REMOVE: begin
          priority if (p_cnt != '0) begin
            res.removed_id       = p_head[ID_W-1:0];
            res.removed_priority = 1'b1;
            p_rd_next            = p_rd_inc;
            p_cnt_next           = p_cnt - CNT_W'(1);
            p_left_next          = (p_cnt > CNT_W'(1)) ? p_after[ENTRY_W-1:ID_W] : '0;
          end else if (n_cnt != '0) begin
            res.removed_id = n_head[ID_W-1:0];
            n_rd_next      = n_rd_inc;
            n_cnt_next     = n_cnt - CNT_W'(1);
            n_left_next    = (n_cnt > CNT_W'(1)) ? n_after[ENTRY_W-1:ID_W] : '0;
          end else begin
            res.status = STATUS_EMPTY;
          end
        end
        default: ;
      endcase
    end

    res.normal_wait   = n_wait_next;
    res.priority_wait = p_wait_next;
    res.current_time  = tick_next;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= cmd;
    end
  end

  // result is written into the output queue during the update cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      n_rd      <= '0;
      n_wr      <= '0;
      p_rd      <= '0;
      p_wr      <= '0;
      n_cnt     <= '0;
      p_cnt     <= '0;
      n_left    <= '0;
      p_left    <= '0;
      n_wait    <= '0;
      p_wait    <= '0;
      tick      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      res_valid <= take;
      n_rd   <= n_rd_next;
      n_wr   <= n_wr_next;
      p_rd   <= p_rd_next;
      p_wr   <= p_wr_next;
      n_cnt  <= n_cnt_next;
      p_cnt  <= p_cnt_next;
      n_left <= n_left_next;
      p_left <= p_left_next;
      n_wait <= n_wait_next;
      p_wait <= p_wait_next;
      tick   <= tick_next;
    end
  end

endmodule

[design/two_class_priority_service_queue.sv]
// channel   | handshake      | payload
// ----------+----------------+-------------------------------------------------
// request   | push / full    | req_type, order_id, service_time
// result    | pop / empty    | status, busy_res, done_res, removed_id,
//           |                | removed_priority, normal_wait, priority_wait,
//           |                | current_time
//
// in the back end a transaction first reads the class heads from the job memories,
// then updates state and writes the result.
// a two-entry request queue and a two-entry result queue sit on either side.
// reset clears counts, pointers, countdowns and totals; job memories need no clear.
// full rises when the request queue holds two transactions; the back end waits
// while the result queue is full.
module two_class_priority_service_queue
  import tcpsq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         req_type,
  input  logic [ID_W-1:0]    order_id,
  input  logic [SVC_W-1:0]   service_time,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         status,
  output logic               busy_res,
  output logic               done_res,
  output logic [ID_W-1:0]    removed_id,
  output logic               removed_priority,
  output logic [TOTAL_W-1:0] normal_wait,
  output logic [TOTAL_W-1:0] priority_wait,
  output logic [TOTAL_W-1:0] current_time
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic res_full;
  logic res_valid;
  res_t res;
  res_t head;

  tcpsq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .req_type     (req_type),
    .order_id     (order_id),
    .service_time (service_time),
    .full         (full),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  tcpsq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_valid (res_valid),
    .res       (res)
  );

  tcpsq_res_fifo u_res_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_valid),
    .wr_data  (res),
    .res_full (res_full),
    .empty    (empty),
    .rd_data  (head),
    .pop      (pop)
  );

  assign status           = head.status;
  assign busy_res         = head.busy_res;
  assign done_res         = head.done_res;
  assign removed_id       = head.removed_id;
  assign removed_priority = head.removed_priority;
  assign normal_wait      = head.normal_wait;
  assign priority_wait    = head.priority_wait;
  assign current_time     = head.current_time;

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  import tcpsq_pkg::*;

  localparam int QDEPTH = 16;
  localparam int NUM_ITEMS = 1700;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_START = 1000;
  localparam int HOLD_LEN = 300;

  typedef struct {
    op_t              op;
    logic [ID_W-1:0]  id;
    logic [SVC_W-1:0] svc;
  } job_req_t;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic [1:0]         req_type;
  logic [ID_W-1:0]    order_id;
  logic [SVC_W-1:0]   service_time;
  logic               empty;
  logic               pop;
  logic [1:0]         status;
  logic               busy_res;
  logic               done_res;
  logic [ID_W-1:0]    removed_id;
  logic               removed_priority;
  logic [TOTAL_W-1:0] normal_wait;
  logic [TOTAL_W-1:0] priority_wait;
  logic [TOTAL_W-1:0] current_time;

  two_class_priority_service_queue #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .req_type         (req_type),
    .order_id         (order_id),
    .service_time     (service_time),
    .empty            (empty),
    .pop              (pop),
    .status           (status),
    .busy_res         (busy_res),
    .done_res         (done_res),
    .removed_id       (removed_id),
    .removed_priority (removed_priority),
    .normal_wait      (normal_wait),
    .priority_wait    (priority_wait),
    .current_time     (current_time)
  );

  job_req_t job_requests[$];
  res_t     owed_results[$];
  int       mismatch_count = 0;

  // shadow queue state, entries are {service time, id}
  logic [31:0]        normal_jobs[$];
  logic [31:0]        prio_jobs[$];
  logic [SVC_W-1:0]   normal_left = '0;
  logic [SVC_W-1:0]   prio_left = '0;
  logic [TOTAL_W-1:0] all_wait = '0;
  logic [TOTAL_W-1:0] prio_wait_sum = '0;
  logic [TOTAL_W-1:0] ticks = '0;

  function automatic logic [TOTAL_W-1:0] add_clamped(input logic [TOTAL_W-1:0] a,
                                                     input logic [SVC_W-1:0] b);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, a} + {{(TOTAL_W+1-SVC_W){1'b0}}, b};
    return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
  endfunction

  function automatic res_t serve_job_request(input job_req_t r);
    res_t        res;
    logic [31:0] head;
    res = '0;
    case (r.op)
      OP_ADD_PRIORITY: begin
        if (prio_jobs.size() >= QDEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          if (prio_jobs.size() == 0) prio_left = r.svc;
          prio_jobs.push_back({r.svc, r.id});
          all_wait = add_clamped(all_wait, r.svc);
          prio_wait_sum = add_clamped(prio_wait_sum, r.svc);
        end
      end
      OP_ADD_NORMAL: begin
        if (normal_jobs.size() >= QDEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          if (normal_jobs.size() == 0) normal_left = r.svc;
          normal_jobs.push_back({r.svc, r.id});
          all_wait = add_clamped(all_wait, r.svc);
        end
      end
      OP_TICK: begin
        ticks = ticks + TOTAL_W'(1);
        // a passed normal job keeps its own countdown
        if (prio_jobs.size() > 0) begin
          res.busy_res = 1'b1;
          res.done_res = (prio_left <= 1);
          if (prio_left != 0) prio_left = prio_left - SVC_W'(1);
        end else if (normal_jobs.size() > 0) begin
          res.busy_res = 1'b1;
          res.done_res = (normal_left <= 1);
          if (normal_left != 0) normal_left = normal_left - SVC_W'(1);
        end
      end
      default: begin
        if (prio_jobs.size() > 0) begin
          head = prio_jobs.pop_front();
          res.removed_id = head[15:0];
          res.removed_priority = 1'b1;
          prio_left = (prio_jobs.size() > 0) ? prio_jobs[0][31:16] : '0;
        end else if (normal_jobs.size() > 0) begin
          head = normal_jobs.pop_front();
          res.removed_id = head[15:0];
          normal_left = (normal_jobs.size() > 0) ? normal_jobs[0][31:16] : '0;
        end else begin
          res.status = STATUS_EMPTY;
        end
      end
    endcase
    res.normal_wait = all_wait;
    res.priority_wait = prio_wait_sum;
    res.current_time = ticks;
    return res;
  endfunction

  task automatic add_req(input op_t op, input logic [ID_W-1:0] id,
                         input logic [SVC_W-1:0] svc);
    job_req_t r;
    r.op = op;
    r.id = id;
    r.svc = svc;
    job_requests.push_back(r);
  endtask

  function automatic logic [SVC_W-1:0] pick_svc();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 6) return SVC_W'($urandom_range(0, 4));
    if (k < 8) return SVC_W'($urandom_range(0, 20));
    return SVC_W'($urandom_range(0, 65535));
  endfunction

  task automatic add_random_job(input int prio_pct);
    op_t op;
    op = ($urandom_range(0, 99) < prio_pct) ? OP_ADD_PRIORITY : OP_ADD_NORMAL;
    add_req(op, ID_W'($urandom_range(0, 65535)), pick_svc());
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // clock and reset
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // request driver: bursts with gaps, junk payload while idle
  int burst_left = 0;
  int gap_left = 0;

  initial begin
    push = 1'b0;
    req_type = '0;
    order_id = '0;
    service_time = '0;
  end

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (gap_left > 0 || job_requests.size() == 0) begin
      push <= 1'b0;
      req_type <= 2'($urandom_range(0, 3));
      order_id <= ID_W'($urandom_range(0, 65535));
      service_time <= SVC_W'($urandom_range(0, 65535));
      if (gap_left > 0) gap_left--;
    end else begin
      push <= 1'b1;
      req_type <= job_requests[0].op;
      order_id <= job_requests[0].id;
      service_time <= job_requests[0].svc;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
  end

  // accepted request transaction -> predicted result
  always @(posedge clk) begin
    job_req_t r;
    if (!rst && push && !full) begin
      r.op = op_t'(req_type);
      r.id = order_id;
      r.svc = service_time;
      owed_results.push_back(serve_job_request(r));
      if (job_requests.size() > 0) job_requests.pop_front();
    end
  end

  // result receiver: changing stall pattern plus one long hold-off
  int rx_cycle = 0;
  int hold_left = 0;
  int stall_mode = 0;

  initial pop = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 50 == 0) stall_mode = $urandom_range(0, 3);
      if (rx_cycle == HOLD_START) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (stall_mode)
          0: pop <= 1'b1;
          1: pop <= ($urandom_range(0, 3) != 0);
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= rx_cycle[0];
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t want;
    if (!rst && pop && !empty) begin
      if (owed_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result transaction with nothing outstanding", $time);
      end else begin
        want = owed_results.pop_front();
        compare_field("status", 32'(want.status), 32'(status));
        compare_field("busy_res", 32'(want.busy_res), 32'(busy_res));
        compare_field("done_res", 32'(want.done_res), 32'(done_res));
        compare_field("removed_id", 32'(want.removed_id), 32'(removed_id));
        compare_field("removed_priority", 32'(want.removed_priority),
                      32'(removed_priority));
        compare_field("normal_wait", want.normal_wait, normal_wait);
        compare_field("priority_wait", want.priority_wait, priority_wait);
        compare_field("current_time", want.current_time, current_time);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int mode;
    int chunk;
    int prio_pct;
    int k;

    // directed: empty cases, zero and max service, class passing
    add_req(OP_REMOVE, 16'h0000, 16'h0000);
    add_req(OP_TICK, 16'hffff, 16'hffff);
    add_req(OP_ADD_NORMAL, 16'hffff, 16'h0000);
    add_req(OP_TICK, 16'h0000, 16'h0000);
    add_req(OP_TICK, 16'h0000, 16'h0000);
    add_req(OP_ADD_NORMAL, 16'h0000, 16'hffff);
    add_req(OP_ADD_PRIORITY, 16'h1234, 16'h0001);
    add_req(OP_TICK, 16'h0000, 16'h0000);
    add_req(OP_TICK, 16'h0000, 16'h0000);
    add_req(OP_REMOVE, 16'h0000, 16'h0000);
    add_req(OP_REMOVE, 16'h0000, 16'h0000);
    add_req(OP_TICK, 16'h0000, 16'h0000);
    add_req(OP_ADD_PRIORITY, 16'haaaa, 16'h0003);
    add_req(OP_TICK, 16'h0000, 16'h0000);
    add_req(OP_REMOVE, 16'h0000, 16'h0000);
    add_req(OP_TICK, 16'h0000, 16'h0000);
    add_req(OP_ADD_PRIORITY, 16'h5555, 16'h0002);
    add_req(OP_REMOVE, 16'h0000, 16'h0000);
    add_req(OP_REMOVE, 16'h0000, 16'h0000);
    add_req(OP_REMOVE, 16'hffff, 16'hffff);
    add_req(OP_ADD_NORMAL, 16'h8001, 16'h7fff);
    add_req(OP_REMOVE, 16'h0000, 16'h0000);

    // overflow both classes, then drain part of them with removes and ticks
    for (k = 0; k < QDEPTH + 1; k++) add_random_job(0);
    for (k = 0; k < QDEPTH + 1; k++) add_random_job(100);
    for (k = 0; k < 2 * QDEPTH + 2; k++) begin
      if (k % 4 == 0) add_req(OP_TICK, 16'h0, 16'h0);
      else add_req(OP_REMOVE, ID_W'($urandom_range(0, 65535)), pick_svc());
    end

    // random chunks with a bias per chunk
    while (job_requests.size() < NUM_ITEMS) begin
      mode = $urandom_range(0, 3);
      chunk = $urandom_range(10, 60);
      prio_pct = $urandom_range(0, 100);
      for (k = 0; k < chunk; k++) begin
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (mode)
          0: begin
            if (roll < 70) add_random_job(prio_pct);
            else if (roll < 85) add_req(OP_TICK, ID_W'($urandom), SVC_W'($urandom));
            else add_req(OP_REMOVE, ID_W'($urandom), SVC_W'($urandom));
          end
          1: begin
            if (roll < 60) add_req(OP_REMOVE, ID_W'($urandom), SVC_W'($urandom));
            else if (roll < 80) add_req(OP_TICK, ID_W'($urandom), SVC_W'($urandom));
            else add_random_job(prio_pct);
          end
          2: begin
            if (roll < 50) add_req(OP_TICK, ID_W'($urandom), SVC_W'($urandom));
            else if (roll < 75) add_req(OP_REMOVE, ID_W'($urandom), SVC_W'($urandom));
            else add_random_job(prio_pct);
          end
          default: begin
            add_req(op_t'($urandom_range(0, 3)), ID_W'($urandom_range(0, 65535)),
                    pick_svc());
          end
        endcase
      end
    end

    @(negedge rst);
    while (job_requests.size() != 0 || owed_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
